FILE: rtl/complex_running_median_defines.svh
// Assertion helpers shared by the running median block.
`ifndef COMPLEX_RUNNING_MEDIAN_DEFINES_SVH
`define COMPLEX_RUNNING_MEDIAN_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRM_ASSERT_NOW(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error("running median check failed");

// The consequent must hold in the cycle after the antecedent.
`define CRM_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error("running median check failed");

`endif

FILE: rtl/crm_pkg.sv
package crm_pkg;

	localparam int MAX_WINDOW   = 31;
	localparam int SAMPLE_BITS  = 24;
	localparam int VAL_W        = 2 * SAMPLE_BITS;
	localparam int KEY_W        = 2 * SAMPLE_BITS + 1;
	localparam int K_W          = 5;
	localparam int PTR_W        = $clog2(MAX_WINDOW);
	localparam int CORDIC_STEPS = 24;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int CX_W         = SAMPLE_BITS + 3;
	localparam int Z_W          = 33;
	localparam int CFG_IDX_W    = 2;

	localparam logic [K_W-1:0] KMAX = K_W'((MAX_WINDOW - 1) | 1);
	localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(64'sd1073741824);

	localparam logic [1:0] ORD_MAG   = 2'd0;
	localparam logic [1:0] ORD_PHASE = 2'd1;
	localparam logic [1:0] ORD_REAL  = 2'd2;
	localparam logic [1:0] ORD_IMAG  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_KERNEL = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ORDER  = CFG_IDX_W'(1);

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [VAL_W-1:0] val_t;

	typedef struct packed {
		key_t key;
		val_t val;
	} entry_t;

	// Travels from cell j+1 down to cell j.
	typedef struct packed {
		entry_t ent;
		logic   lt;
	} link_dn_t;

	// Travels from cell j up to cell j+1.
	typedef struct packed {
		entry_t ent;
		logic   gt;
	} link_up_t;

	typedef struct packed {
		logic load;
		logic shift;
		key_t key;
		key_t old;
		val_t val;
	} cell_cmd_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_real;
		logic signed [SAMPLE_BITS-1:0] sample_imag;
		logic                          end_of_trace;
	} in_beat_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] median_real;
		logic signed [SAMPLE_BITS-1:0] median_imag;
		logic                          final_result;
	} out_beat_t;

	function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] i);
		logic signed [Z_W-1:0] r;
		unique case (i)
			5'd0:  r = Z_W'(536870912);
			5'd1:  r = Z_W'(316933406);
			5'd2:  r = Z_W'(167458907);
			5'd3:  r = Z_W'(85004756);
			5'd4:  r = Z_W'(42667331);
			5'd5:  r = Z_W'(21354465);
			5'd6:  r = Z_W'(10679838);
			5'd7:  r = Z_W'(5340245);
			5'd8:  r = Z_W'(2670163);
			5'd9:  r = Z_W'(1335087);
			5'd10: r = Z_W'(667544);
			5'd11: r = Z_W'(333772);
			5'd12: r = Z_W'(166886);
			5'd13: r = Z_W'(83443);
			5'd14: r = Z_W'(41722);
			5'd15: r = Z_W'(20861);
			5'd16: r = Z_W'(10430);
			5'd17: r = Z_W'(5215);
			5'd18: r = Z_W'(2608);
			5'd19: r = Z_W'(1304);
			5'd20: r = Z_W'(652);
			5'd21: r = Z_W'(326);
			5'd22: r = Z_W'(163);
			5'd23: r = Z_W'(81);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/crm_key.sv
module crm_key (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [1:0]                             order,
	input  logic signed [crm_pkg::SAMPLE_BITS-1:0] re,
	input  logic signed [crm_pkg::SAMPLE_BITS-1:0] im,
	output logic                                   done,
	output crm_pkg::key_t                          key
);
	import crm_pkg::*;

	logic                    busy_q, done_q;
	logic [1:0]              ord_q;
	logic [STEP_W-1:0]       step_q;
	logic signed [CX_W-1:0]  x_q, y_q, x_n, y_n, dx, dy, re_x, im_x;
	logic signed [Z_W-1:0]   z_q, z_n;
	logic signed [VAL_W-1:0] pr_q, pi_q;
	key_t                    key_q;

	assign re_x = CX_W'(re);
	assign im_x = CX_W'(im);
	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;

	always_comb begin
		if (!y_q[CX_W-1]) begin
			x_n = x_q + dx;
			y_n = y_q - dy;
			z_n = z_q + atan_step(step_q);
		end else begin
			x_n = x_q - dx;
			y_n = y_q + dy;
			z_n = z_q - atan_step(step_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ord_q  <= ORD_MAG;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				ord_q  <= order;
				step_q <= '0;
			end else if (busy_q) begin
				if (ord_q != ORD_PHASE || step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pr_q  <= re * re;
			pi_q  <= im * im;
			key_q <= (order == ORD_REAL) ? KEY_W'(re) : KEY_W'(im);
			z_q   <= '0;
			x_q   <= re_x;
			y_q   <= im_x;
			// Vectors in the left half plane are turned a quarter first.
			if (re_x < 0) begin
				if (im_x >= 0) begin
					x_q <= im_x;
					y_q <= -re_x;
					z_q <= QUARTER_TURN;
				end else begin
					x_q <= -im_x;
					y_q <= re_x;
					z_q <= -QUARTER_TURN;
				end
			end
		end else if (busy_q) begin
			if (ord_q == ORD_PHASE) begin
				x_q <= x_n;
				y_q <= y_n;
				z_q <= z_n;
				if (step_q == STEP_W'(CORDIC_STEPS - 1))
					key_q <= KEY_W'(z_n);
			end else if (ord_q == ORD_MAG) begin
				key_q <= KEY_W'(pr_q) + KEY_W'(pi_q);
			end
		end
	end

	assign done = done_q;
	assign key  = key_q;

endmodule

FILE: rtl/crm_cell.sv
module crm_cell (
	input  logic                clk,
	input  crm_pkg::cell_cmd_t  cmd,
	input  logic                last,
	input  crm_pkg::link_dn_t   from_up,
	input  crm_pkg::link_up_t   from_dn,
	output crm_pkg::link_dn_t   to_dn,
	output crm_pkg::link_up_t   to_up
);
	import crm_pkg::*;

	entry_t ent_q, d, nxt;
	logic   ge, lt, del, gt;

	// The window is sorted, so both compares are monotone along the row and
	// each cell can decide its own move from its neighbors alone.
	assign ge  = !(ent_q.key < cmd.old);
	assign lt  = cmd.key < ent_q.key;
	assign del = ge || last;
	assign d   = del ? from_up.ent : ent_q;
	assign gt  = last ? 1'b1 : (del ? from_up.lt : lt);

	always_comb begin
		if (!gt)
			nxt = d;
		else if (from_dn.gt)
			nxt = from_dn.ent;
		else
			nxt = '{key: cmd.key, val: cmd.val};
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			ent_q <= '{key: cmd.key, val: cmd.val};
		else if (cmd.shift)
			ent_q <= nxt;
	end

	assign to_dn = '{ent: ent_q, lt: lt};
	assign to_up = '{ent: d, gt: gt};

endmodule

FILE: rtl/complex_running_median.sv
// Each item passes the key state (magnitude, real or imaginary key, or the phase
// CORDIC), then a window update and a select state before the result is shown.
// A new item is taken only in idle, once the last one is through: after its result
// is taken, or after select when it gives none, and after one update and select per
// flush step on a last-marked item; each shown result waits until it is taken.
// Reset: asynchronous active low; kernel_size 3, key order magnitude, no trace open.
`include "complex_running_median_defines.svh"
module complex_running_median (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  crm_pkg::in_beat_t                 sample,
	output logic                              median_valid,
	input  logic                              median_stall,
	output crm_pkg::out_beat_t                median,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [crm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [crm_pkg::K_W-1:0]           cfg_data
);
	import crm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_KEY  = 3'd1;
	localparam logic [2:0] S_UPD  = 3'd2;
	localparam logic [2:0] S_SEL  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]           state_q;
	logic [K_W-1:0]       kernel_q, act_k_q, k_sel, k_new;
	logic [1:0]           order_q, act_ord_q, ord_new;
	logic                 open_q, load_q, eot_q, out_valid_q, accept, start;
	logic [K_W-2:0]       flush_q, h;
	logic [K_W-1:0]       count_q;
	logic [PTR_W-1:0]     ptr_q;
	val_t                 val_q;
	key_t                 arr_q [MAX_WINDOW];
	key_t                 kkey;
	logic                 kdone;
	out_beat_t            out_q;
	cell_cmd_t            cmd;
	link_dn_t             dn_link [MAX_WINDOW];
	link_up_t             up_link [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] last;
	entry_t               mid;
	logic                 more;

	assign k_sel   = kernel_q | K_W'(1);
	assign k_new   = open_q ? act_k_q : ((k_sel > KMAX) ? KMAX : k_sel);
	assign ord_new = open_q ? act_ord_q : order_q;
	assign h       = act_k_q[K_W-1:1];
	assign accept  = sample_valid && !sample_stall;
	assign start   = accept;
	assign more    = eot_q && (flush_q != '0);

	assign sample_stall = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;

	crm_key u_key (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.order  (ord_new),
		.re     (sample.sample_real),
		.im     (sample.sample_imag),
		.done   (kdone),
		.key    (kkey)
	);

	assign cmd = '{load: (state_q == S_UPD) && load_q,
		shift: (state_q == S_UPD) && !load_q,
		key: kkey, old: arr_q[ptr_q], val: val_q};

	genvar j;
	generate
		for (j = 0; j < MAX_WINDOW; j++) begin : g_cell
			link_dn_t up_in;
			link_up_t dn_in;
			assign last[j] = (PTR_W'(j) >= act_k_q - K_W'(1));
			if (j == MAX_WINDOW - 1) begin : g_top
				assign up_in = dn_link[j];
			end else begin : g_mid
				assign up_in = dn_link[j+1];
			end
			if (j == 0) begin : g_bot
				assign dn_in = '0;
			end else begin : g_rest
				assign dn_in = up_link[j-1];
			end
			crm_cell u_cell (
				.clk     (clk),
				.cmd     (cmd),
				.last    (last[j]),
				.from_up (up_in),
				.from_dn (dn_in),
				.to_dn   (dn_link[j]),
				.to_up   (up_link[j])
			);
		end
	endgenerate

	assign mid = dn_link[PTR_W'(h)].ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q  <= K_W'(3);
			order_q   <= ORD_MAG;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_KERNEL)
				kernel_q <= cfg_data;
			else if (cfg_index == REG_ORDER)
				order_q <= cfg_data[1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			act_k_q     <= K_W'(1);
			act_ord_q   <= ORD_MAG;
			open_q      <= 1'b0;
			load_q      <= 1'b0;
			eot_q       <= 1'b0;
			flush_q     <= '0;
			count_q     <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_k_q   <= k_new;
						act_ord_q <= ord_new;
						load_q    <= !open_q;
						open_q    <= 1'b1;
						eot_q     <= sample.end_of_trace;
						flush_q   <= k_new[K_W-1:1];
						state_q   <= S_KEY;
					end
				end
				S_KEY: begin
					if (kdone)
						state_q <= S_UPD;
				end
				S_UPD: begin
					if (load_q) begin
						ptr_q   <= '0;
						count_q <= K_W'(1);
					end else begin
						ptr_q <= (ptr_q == PTR_W'(act_k_q - K_W'(1))) ? '0 : ptr_q + 1'b1;
						if (count_q != '1)
							count_q <= count_q + 1'b1;
					end
					load_q  <= 1'b0;
					state_q <= S_SEL;
				end
				S_SEL: begin
					if (count_q > K_W'(h)) begin
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end else if (more) begin
						flush_q <= flush_q - 1'b1;
						state_q <= S_UPD;
					end else begin
						if (eot_q) begin
							open_q  <= 1'b0;
							count_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (!median_stall) begin
						out_valid_q <= 1'b0;
						if (more) begin
							flush_q <= flush_q - 1'b1;
							state_q <= S_UPD;
						end else begin
							if (eot_q) begin
								open_q  <= 1'b0;
								count_q <= '0;
							end
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			val_q <= {sample.sample_real, sample.sample_imag};
		if (state_q == S_UPD) begin
			if (load_q) begin
				for (int i = 0; i < MAX_WINDOW; i++)
					arr_q[i] <= kkey;
			end else begin
				arr_q[ptr_q] <= kkey;
			end
		end
		if (state_q == S_SEL) begin
			// The final beat of a trace is the one that closes its last flush step.
			out_q <= '{median_real: mid.val[VAL_W-1:SAMPLE_BITS],
				median_imag: mid.val[SAMPLE_BITS-1:0],
				final_result: eot_q && (flush_q == '0)};
		end
	end

	assign median_valid = out_valid_q;
	assign median       = out_q;

	`CRM_ASSERT_NOW(a_valid_in_out, median_valid, state_q == S_OUT)
	`CRM_ASSERT_NOW(a_no_accept_while_busy, median_valid, sample_stall)
	`CRM_ASSERT_NOW(a_key_done_when_waiting, kdone, state_q == S_KEY)
	`CRM_ASSERT_NEXT(a_final_closes, median_valid && median.final_result && !median_stall,
		state_q == S_IDLE && !open_q)

endmodule

FILE: test/complex_running_median_test.sv
module complex_running_median_test;
	import crm_pkg::*;

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_stall;
	in_beat_t sample;
	logic median_valid;
	logic median_stall;
	out_beat_t median;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [K_W-1:0] cfg_data;

	complex_running_median uut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
		.median_valid(median_valid), .median_stall(median_stall), .median(median),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state.
	logic [K_W-1:0] kernel_reg;
	logic [1:0] order_reg;
	val_t win_vals [MAX_WINDOW];
	longint win_keys [MAX_WINDOW];
	longint fifo_keys [MAX_WINDOW];
	int seen_count;
	bit in_trace;
	int oldest_ptr;
	int win_len;
	logic [1:0] win_order;

	out_beat_t pending_medians [$];
	int mismatches;
	int send_idle_pct;
	int recv_stall_pct;

	localparam longint ATAN_TAB [CORDIC_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200000000;
		$display("complex_running_median_test: FAIL");
		$finish;
	end

	function automatic longint cordic_angle(longint x, longint y);
		longint z, t, dx, dy;
		z = 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = 1073741824;
			end else begin
				x = -y; y = t; z = -1073741824;
			end
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += ATAN_TAB[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_TAB[i];
			end
		end
		return z;
	endfunction

	function automatic longint sort_key(longint re, longint im);
		case (win_order)
			ORD_MAG: return re * re + im * im;
			ORD_PHASE: return cordic_angle(re, im);
			ORD_REAL: return re;
			default: return im;
		endcase
	endfunction

	task automatic slide_window(val_t v, longint key);
		int p, q;
		longint gone;
		p = 0;
		q = 0;
		gone = fifo_keys[oldest_ptr];
		while (p < win_len && win_keys[p] < gone) p++;
		if (p >= win_len) p = win_len - 1;
		for (int i = p; i + 1 < win_len; i++) begin
			win_keys[i] = win_keys[i+1];
			win_vals[i] = win_vals[i+1];
		end
		while (q < win_len - 1 && !(key < win_keys[q])) q++;
		for (int i = win_len - 1; i > q; i--) begin
			win_keys[i] = win_keys[i-1];
			win_vals[i] = win_vals[i-1];
		end
		win_keys[q] = key;
		win_vals[q] = v;
		fifo_keys[oldest_ptr] = key;
		oldest_ptr = (oldest_ptr + 1 >= win_len) ? 0 : oldest_ptr + 1;
		if (seen_count < 31) seen_count++;
	endtask

	task automatic push_median(inout int made);
		int h;
		out_beat_t r;
		h = (win_len - 1) / 2;
		if (seen_count > h) begin
			r.median_real = win_vals[h][VAL_W-1:SAMPLE_BITS];
			r.median_imag = win_vals[h][SAMPLE_BITS-1:0];
			r.final_result = 1'b0;
			pending_medians.push_back(r);
			made++;
		end
	endtask

	task automatic predict_median(in_beat_t s);
		longint re, im, key;
		val_t v;
		int made, k;
		out_beat_t r;
		re = s.sample_real;
		im = s.sample_imag;
		v = {s.sample_real, s.sample_imag};
		made = 0;
		if (!in_trace) begin
			k = kernel_reg | 1;
			win_len = k > KMAX ? KMAX : k;
			win_order = order_reg;
			key = sort_key(re, im);
			for (int i = 0; i < win_len; i++) begin
				win_vals[i] = v; win_keys[i] = key; fifo_keys[i] = key;
			end
			oldest_ptr = 0;
			seen_count = 1;
			in_trace = 1;
		end else begin
			key = sort_key(re, im);
			slide_window(v, key);
		end
		push_median(made);
		if (s.end_of_trace) begin
			for (int i = 0; i < (win_len - 1) / 2; i++) begin
				slide_window(v, key);
				push_median(made);
			end
			if (made > 0) begin
				r = pending_medians.pop_back();
				r.final_result = 1'b1;
				pending_medians.push_back(r);
			end
			in_trace = 0;
			seen_count = 0;
		end
	endtask

	// Result checker and receiver stall generator.
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && median_valid && !median_stall) begin
			if (pending_medians.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected median beat %h", median);
			end else begin
				want = pending_medians.pop_front();
				if (median.median_real !== want.median_real ||
						median.median_imag !== want.median_imag ||
						median.final_result !== want.final_result) begin
					mismatches++;
					if (mismatches <= 10)
						$display("median mismatch: expected %h %h %b got %h %h %b",
							want.median_real, want.median_imag, want.final_result,
							median.median_real, median.median_imag, median.final_result);
				end
			end
		end
		median_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_sample(logic signed [23:0] re, logic signed [23:0] im, logic last);
		in_beat_t s;
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		s.sample_real = re;
		s.sample_imag = im;
		s.end_of_trace = last;
		sample <= s;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		predict_median(s);
		// Valid goes low between beats.
		sample_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain;
		int guard;
		guard = 0;
		@(posedge clk);
		while (pending_medians.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [K_W-1:0] d);
		cfg_index <= idx;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_KERNEL) kernel_reg = d;
		else if (idx == REG_ORDER) order_reg = d[1:0];
		@(posedge clk);
	endtask

	function automatic logic signed [23:0] edge_value();
		case ($urandom_range(4))
			0: return 24'sh800000;
			1: return 24'sh7fffff;
			2: return 24'sh000000;
			3: return 24'shffffff;
			default: return 24'sh000001;
		endcase
	endfunction

	task automatic test_directed;
		write_reg(REG_KERNEL, 5'd3);
		write_reg(REG_ORDER, K_W'(ORD_MAG));
		send_sample(24'sh7fffff, 24'sh800000, 0);
		send_sample(24'sh800000, 24'sh7fffff, 0);
		send_sample(24'sh000000, 24'sh000000, 0);
		send_sample(24'sh100000, 24'sh100000, 1);
		// A single-sample trace produces exactly one final result.
		send_sample(24'sh123456, -24'sh654321, 1);
		drain();
		write_reg(REG_KERNEL, 5'd0);
		write_reg(REG_ORDER, K_W'(ORD_PHASE));
		send_sample(-24'sh100000, 24'sh000000, 0);
		send_sample(-24'sh100000, -24'sh000001, 0);
		send_sample(24'sh000000, -24'sh400000, 1);
		drain();
		write_reg(REG_KERNEL, 5'd31);
		write_reg(REG_ORDER, K_W'(ORD_REAL));
		for (int i = 0; i < 6; i++) send_sample(24'sh000005, 24'(i), i == 5);
		drain();
		write_reg(REG_KERNEL, 5'd4);
		write_reg(REG_ORDER, K_W'(ORD_IMAG));
		for (int i = 0; i < 6; i++) send_sample(edge_value(), edge_value(), i == 5);
		drain();
	endtask

	task automatic random_traces(int n_items);
		int sent, len, dup;
		logic signed [23:0] re, im;
		sent = 0;
		while (sent < n_items) begin
			write_reg(REG_KERNEL, ($urandom_range(3) == 0) ? 5'($urandom_range(31))
				: 5'($urandom_range(7)));
			write_reg(REG_ORDER, K_W'($urandom_range(3)));
			len = $urandom_range(1, 20);
			for (int i = 0; i < len; i++) begin
				dup = $urandom_range(9);
				if (dup < 2 && i > 0) begin
					// Repeat the previous sample to make equal keys.
				end else if (dup < 4) begin
					re = edge_value(); im = edge_value();
				end else begin
					re = 24'($urandom); im = 24'($urandom);
				end
				send_sample(re, im, i == len - 1);
				sent++;
			end
			drain();
		end
	endtask

	task automatic test_no_idle;
		send_idle_pct = 0; recv_stall_pct = 0;
		random_traces(72);
	endtask

	task automatic test_sender_idle;
		send_idle_pct = 50; recv_stall_pct = 0;
		random_traces(72);
	endtask

	task automatic test_receiver_stall;
		send_idle_pct = 0; recv_stall_pct = 50;
		random_traces(72);
	endtask

	task automatic test_both_idle;
		send_idle_pct = 17; recv_stall_pct = 17;
		random_traces(72);
	endtask

	initial begin
		arst_n = 0;
		sample_valid = 0;
		sample = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		kernel_reg = 5'd3;
		order_reg = ORD_MAG;
		in_trace = 0;
		seen_count = 0;
		oldest_ptr = 0;
		win_len = 1;
		win_order = ORD_MAG;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			win_vals[i] = '0; win_keys[i] = 0; fifo_keys[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		drain();
		if (mismatches == 0 && pending_medians.size() == 0)
			$display("complex_running_median_test: PASS");
		else
			$display("complex_running_median_test: FAIL");
		$finish;
	end

endmodule
